// File: design/hdtl_pkg.sv
// ----------------------------------------------------------------------------
// hdtl_pkg
// shared constants, codes and types of the huffman tree loader and decoder
// ----------------------------------------------------------------------------
package hdtl_pkg;

    localparam int SYMBOL_BITS = 8;
    localparam int MAX_NODES   = 511;
    localparam int STACK_DEPTH = 256;

    localparam int NODE_AW  = $clog2(MAX_NODES);
    localparam int CNT_W    = $clog2(MAX_NODES + 1);
    localparam int STACK_AW = $clog2(STACK_DEPTH);
    localparam int DEPTH_W  = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] LEAF_MARK = 8'h4C;

    localparam logic OP_TREE = 1'b0;
    localparam logic OP_BIT  = 1'b1;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_MID_CODE  = 2'd1,
        ERR_NOT_READY = 2'd2,
        ERR_OVERFLOW  = 2'd3
    } err_t;

    // what a node entry knows about one of its children
    typedef struct packed {
        logic [NODE_AW-1:0]     idx;
        logic                   leaf;
        logic [SYMBOL_BITS-1:0] sym;
    } child_t;

    localparam int CHILD_W = $bits(child_t);

    typedef struct packed {
        logic               left_we;
        logic               right_we;
        logic [NODE_AW-1:0] addr;
        child_t             data;
    } node_wr_t;

    typedef struct packed {
        logic                   ready;
        logic                   root_leaf;
        logic [SYMBOL_BITS-1:0] root_sym;
        logic                   walk_clear;
    } tree_info_t;

    typedef struct packed {
        logic                   valid;
        logic [SYMBOL_BITS-1:0] sym;
        logic                   sym_valid;
        logic                   done;
        err_t                   err;
    } result_t;

endpackage

// File: design/hdtl_ram.sv
// ----------------------------------------------------------------------------
// hdtl_ram
// simple dual port ram, one write port, one registered read port, write-first
// ----------------------------------------------------------------------------
module hdtl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        // a write to the address being read shows up at once
        if (we && (waddr == raddr)) begin
            rdata <= wdata;
        end else begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/hdtl_loader.sv
// ----------------------------------------------------------------------------
// hdtl_loader
// builds the node table from preorder tree bytes with a pending-node stack
// ----------------------------------------------------------------------------
module hdtl_loader (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         start,
    input  logic [7:0]                   tree_byte,
    output hdtl_pkg::node_wr_t           node_wr,
    output hdtl_pkg::tree_info_t         info,
    output hdtl_pkg::result_t            res
);
    import hdtl_pkg::*;

    logic                   ready_reg, ready_next, ready_e;
    logic                   failed_reg, failed_next, failed_e;
    logic                   await_reg, await_next, await_e;
    logic [DEPTH_W-1:0]     depth_reg, depth_next, depth_e, depth_sel, after;
    logic [CNT_W-1:0]       used_reg, used_next, used_e;
    logic [NODE_AW-1:0]     top_idx_reg, top_idx_next;
    logic                   top_flag_reg, top_flag_next;
    logic [NODE_AW-1:0]     pend_addr_reg, pend_addr_next;
    logic [NODE_AW-1:0]     pend_idx_reg, pend_idx_next;
    logic                   pend_side_reg, pend_side_next;
    logic                   pend_root_reg, pend_root_next;
    logic                   root_leaf_reg, root_leaf_next;
    logic [SYMBOL_BITS-1:0] root_sym_reg, root_sym_next;
    logic [NODE_AW-1:0]     n_idx;
    logic                   is_mark, completing;
    logic                   stk_we;
    logic [STACK_AW-1:0]    stk_waddr, stk_raddr;
    logic [NODE_AW-1:0]     stk_rdata;
    node_wr_t               wr;
    result_t                r;

    // entries below the top of stack; the top itself lives in flip-flops
    hdtl_ram #(
        .WIDTH (NODE_AW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (top_idx_reg),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    always_comb begin
        ready_e  = start ? 1'b0 : ready_reg;
        failed_e = start ? 1'b0 : failed_reg;
        await_e  = start ? 1'b0 : await_reg;
        depth_e  = start ? '0   : depth_reg;
        used_e   = start ? '0   : used_reg;
        n_idx    = used_e[NODE_AW-1:0];
        is_mark  = (tree_byte == LEAF_MARK);
        after    = depth_e - DEPTH_W'((used_e != '0) && top_flag_reg);

        ready_next     = ready_e;
        failed_next    = failed_e;
        await_next     = await_e;
        depth_next     = depth_e;
        used_next      = used_e;
        top_idx_next   = top_idx_reg;
        top_flag_next  = top_flag_reg;
        pend_addr_next = pend_addr_reg;
        pend_idx_next  = pend_idx_reg;
        pend_side_next = pend_side_reg;
        pend_root_next = pend_root_reg;
        root_leaf_next = root_leaf_reg;
        root_sym_next  = root_sym_reg;
        completing     = 1'b0;
        stk_we         = 1'b0;
        stk_waddr      = STACK_AW'(depth_e - DEPTH_W'(1));
        wr             = '0;
        r              = '0;
        r.err          = ERR_NONE;

        if (ready_e || failed_e) begin
            // tree done or load failed: byte ignored
        end else if (await_e) begin
            await_next = 1'b0;
            if (pend_root_reg) begin
                root_sym_next = tree_byte;
            end else begin
                wr.left_we  = !pend_side_reg;
                wr.right_we = pend_side_reg;
                wr.addr     = pend_addr_reg;
                wr.data     = '{idx: pend_idx_reg, leaf: 1'b1, sym: tree_byte};
            end
            if (depth_e == '0) begin
                ready_next = 1'b1;
                completing = 1'b1;
                r.valid    = 1'b1;
                r.done     = 1'b1;
            end
        end else if ((used_e >= CNT_W'(MAX_NODES)) || ((used_e != '0) && (depth_e == '0))) begin
            failed_next = 1'b1;
            r.valid     = 1'b1;
            r.err       = ERR_OVERFLOW;
        end else if (!is_mark && (after >= DEPTH_W'(STACK_DEPTH))) begin
            failed_next = 1'b1;
            r.valid     = 1'b1;
            r.err       = ERR_OVERFLOW;
        end else begin
            used_next = used_e + CNT_W'(1);
            if (used_e != '0) begin
                pend_addr_next = top_idx_reg;
                pend_side_next = top_flag_reg;
                pend_idx_next  = n_idx;
                if (is_mark) begin
                    pend_root_next = 1'b0;
                end
                if (!top_flag_reg) begin
                    if (is_mark) begin
                        top_flag_next = 1'b1;
                    end else begin
                        // left child internal: push it, parent now left-filled
                        wr.left_we    = 1'b1;
                        wr.addr       = top_idx_reg;
                        wr.data       = '{idx: n_idx, leaf: 1'b0, sym: '0};
                        stk_we        = 1'b1;
                        top_idx_next  = n_idx;
                        top_flag_next = 1'b0;
                        depth_next    = depth_e + DEPTH_W'(1);
                    end
                end else begin
                    if (is_mark) begin
                        // right leaf: parent done, pop
                        top_idx_next  = stk_rdata;
                        top_flag_next = 1'b1;
                        depth_next    = depth_e - DEPTH_W'(1);
                    end else begin
                        // right internal: pop and push in place
                        wr.right_we   = 1'b1;
                        wr.addr       = top_idx_reg;
                        wr.data       = '{idx: n_idx, leaf: 1'b0, sym: '0};
                        top_idx_next  = n_idx;
                        top_flag_next = 1'b0;
                    end
                end
            end else begin
                if (is_mark) begin
                    root_leaf_next = 1'b1;
                    pend_root_next = 1'b1;
                end else begin
                    root_leaf_next = 1'b0;
                    top_idx_next   = '0;
                    top_flag_next  = 1'b0;
                    depth_next     = DEPTH_W'(1);
                end
            end
            if (is_mark) begin
                await_next = 1'b1;
            end
        end
    end

    // prefetch the entry that sits under the next top of stack
    assign depth_sel = en ? depth_next : depth_reg;
    assign stk_raddr = STACK_AW'(depth_sel - DEPTH_W'(2));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_reg  <= 1'b0;
            failed_reg <= 1'b0;
            await_reg  <= 1'b0;
            depth_reg  <= '0;
            used_reg   <= '0;
        end else if (en) begin
            ready_reg  <= ready_next;
            failed_reg <= failed_next;
            await_reg  <= await_next;
            depth_reg  <= depth_next;
            used_reg   <= used_next;
        end
        if (en) begin
            top_idx_reg   <= top_idx_next;
            top_flag_reg  <= top_flag_next;
            pend_addr_reg <= pend_addr_next;
            pend_idx_reg  <= pend_idx_next;
            pend_side_reg <= pend_side_next;
            pend_root_reg <= pend_root_next;
            root_leaf_reg <= root_leaf_next;
            root_sym_reg  <= root_sym_next;
        end
    end

    always_comb begin
        node_wr          = wr;
        node_wr.left_we  = wr.left_we && en;
        node_wr.right_we = wr.right_we && en;
        res              = r;
        res.valid        = r.valid && en;
        info.ready       = ready_reg;
        info.root_leaf   = root_leaf_reg;
        info.root_sym    = root_sym_reg;
        info.walk_clear  = en && (start || completing);
    end

endmodule

// File: design/hdtl_walker.sv
// ----------------------------------------------------------------------------
// hdtl_walker
// walks the node table one code bit at a time and emits decoded symbols
// ----------------------------------------------------------------------------
module hdtl_walker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          code_bit,
    input  logic                          last_bit,
    input  hdtl_pkg::tree_info_t          info,
    input  hdtl_pkg::child_t              left_rd,
    input  hdtl_pkg::child_t              right_rd,
    output logic [hdtl_pkg::NODE_AW-1:0]  raddr,
    output hdtl_pkg::result_t             res
);
    import hdtl_pkg::*;

    logic [NODE_AW-1:0] walk_reg, walk_next;
    child_t             ch;

    always_comb begin
        ch        = code_bit ? right_rd : left_rd;
        walk_next = walk_reg;
        res       = '0;
        res.err   = ERR_NONE;
        if (info.walk_clear) begin
            walk_next = '0;
        end else if (en) begin
            res.valid = 1'b1;
            if (!info.ready) begin
                res.err = ERR_NOT_READY;
            end else if ((walk_reg == '0) && info.root_leaf) begin
                // single-leaf tree
                res.sym       = info.root_sym;
                res.sym_valid = 1'b1;
            end else if (ch.leaf) begin
                res.sym       = ch.sym;
                res.sym_valid = 1'b1;
                walk_next     = '0;
            end else if (last_bit) begin
                res.err   = ERR_MID_CODE;
                walk_next = '0;
            end else begin
                res.valid = 1'b0;
                walk_next = ch.idx;
            end
        end
    end

    // node table is read at the next walk position, ready for the next bit
    assign raddr = walk_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_reg <= '0;
        end else begin
            walk_reg <= walk_next;
        end
    end

endmodule

// File: design/huffman_tree_load_and_decode.sv
// ----------------------------------------------------------------------------
// huffman_tree_load_and_decode
// loads a huffman tree from preorder bytes, then decodes code bits to symbols
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata fields, lowest bit up                  | tuser     | tlast
//  ---------+-----+----------------------------------------------+-----------+---------
//  s_       | in  | tree_start[0] tree_byte[8:1] code_bit[9]     | operation | last_bit
//  m_       | out | symbol[7:0] symbol_valid[8] tree_complete[9] | -         | -
//           |     | error_code[11:10]                            |           |
//
//  one word per cycle while the result register is not stalled; a word is held
//  in the input register, then one pass of logic feeds the result register
//  the walk rate is set by the node table read port, which is fetched at the
//  next walk node in the same cycle that a bit moves the walk
//  reset clears control state only; node table and stack hold garbage until
//  a tree is loaded, and no clearing pass is run
//  a stalled result holds the input register, which then stops s_tready
//
module huffman_tree_load_and_decode (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // tree_start, tree_byte[7:0], code_bit, zero fill
    input  logic        s_tuser,   // operation
    input  logic        s_tlast,   // last_bit
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // symbol[7:0], symbol_valid, tree_complete,
                                   // error_code[1:0], zero fill
);
    import hdtl_pkg::*;

    // input register
    logic                   in_valid_reg;
    logic                   in_op_reg;
    logic                   in_start_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_bit_reg;
    logic                   in_last_reg;

    // result register
    logic                   out_valid_reg, out_valid_next;
    logic [SYMBOL_BITS-1:0] out_sym_reg;
    logic                   out_sym_valid_reg;
    logic                   out_done_reg;
    err_t                   out_err_reg;

    logic                   advance;
    logic                   load_en, walk_en;
    node_wr_t               node_wr;
    tree_info_t             tree_info;
    result_t                load_res, walk_res, res;
    logic [NODE_AW-1:0]     node_raddr;
    logic [CHILD_W-1:0]     left_rdata, right_rdata;

    // the held word moves on when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign load_en  = advance && (in_op_reg == OP_TREE);
    assign walk_en  = advance && (in_op_reg == OP_BIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_op_reg    <= s_tuser;
            in_start_reg <= s_tdata[0];
            in_byte_reg  <= s_tdata[8:1];
            in_bit_reg   <= s_tdata[9];
            in_last_reg  <= s_tlast;
        end
    end

    // tree builder with its pending-node stack
    hdtl_loader u_loader (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (load_en),
        .start     (in_start_reg),
        .tree_byte (in_byte_reg),
        .node_wr   (node_wr),
        .info      (tree_info),
        .res       (load_res)
    );

    // node table, split by side; each entry also carries its child's leaf
    // flag and symbol so one read settles a bit
    hdtl_ram #(
        .WIDTH (CHILD_W),
        .DEPTH (MAX_NODES)
    ) u_left_tbl (
        .aclk  (aclk),
        .we    (node_wr.left_we),
        .waddr (node_wr.addr),
        .wdata (node_wr.data),
        .raddr (node_raddr),
        .rdata (left_rdata)
    );

    hdtl_ram #(
        .WIDTH (CHILD_W),
        .DEPTH (MAX_NODES)
    ) u_right_tbl (
        .aclk  (aclk),
        .we    (node_wr.right_we),
        .waddr (node_wr.addr),
        .wdata (node_wr.data),
        .raddr (node_raddr),
        .rdata (right_rdata)
    );

    // bit walker
    hdtl_walker u_walker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (walk_en),
        .code_bit (in_bit_reg),
        .last_bit (in_last_reg),
        .info     (tree_info),
        .left_rd  (child_t'(left_rdata)),
        .right_rd (child_t'(right_rdata)),
        .raddr    (node_raddr),
        .res      (walk_res)
    );

    assign res = (in_op_reg == OP_BIT) ? walk_res : load_res;

    always_comb begin
        if (advance && res.valid) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (advance && res.valid) begin
            out_sym_reg       <= res.sym;
            out_sym_valid_reg <= res.sym_valid;
            out_done_reg      <= res.done;
            out_err_reg       <= res.err;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_err_reg, out_done_reg, out_sym_valid_reg, out_sym_reg};

`ifndef SYNTH
    // a decoded symbol never comes with an error or a completion flag
    a_sym_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[8]) |-> ((m_tdata[11:10] == ERR_NONE) && !m_tdata[9]))
        else $error("decoded symbol carries error or completion flag");

    // symbols are only decoded from a finished tree
    a_sym_needs_tree: assert property (@(posedge aclk) disable iff (!aresetn)
        (walk_en && walk_res.sym_valid) |-> tree_info.ready)
        else $error("symbol decoded before tree was ready");

    // node table is written only by an accepted tree byte
    a_tbl_write_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (node_wr.left_we || node_wr.right_we) |-> load_en)
        else $error("node table written outside a tree byte");

    // the walk is back at the root after a tree is started or completed
    a_walk_root: assert property (@(posedge aclk) disable iff (!aresetn)
        tree_info.walk_clear |=> (node_raddr == '0 || walk_en))
        else $error("walk not returned to root after tree change");
`endif

endmodule

// File: sim/hdtl_checker.sv
// ----------------------------------------------------------------------------
// hdtl_checker
// watches both channels of the huffman tree decoder, predicts every result
// word from the accepted input words and compares them field by field
// ----------------------------------------------------------------------------
module hdtl_checker
    import hdtl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // tree_start, tree_byte[7:0], code_bit, zero fill
    input  logic        s_tuser,   // operation
    input  logic        s_tlast,   // last_bit
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // symbol[7:0], symbol_valid, tree_complete,
                                   // error_code[1:0], zero fill
    output int          fail_count,
    output int          pending,
    output int          n_words,
    output int          n_symbols,
    output int          n_trees,
    output int          n_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [SYMBOL_BITS-1:0] symbol;
        logic                   sym_valid;
        logic                   done;
        err_t                   err;
    } sym_word_t;

    // decoder image: node table, pending-node stack and walk position
    logic [NODE_AW-1:0]     left_of   [MAX_NODES];
    logic [NODE_AW-1:0]     right_of  [MAX_NODES];
    logic                   leaf_flag [MAX_NODES];
    logic [SYMBOL_BITS-1:0] leaf_sym  [MAX_NODES];
    logic [NODE_AW:0]       open_stack [STACK_DEPTH];   // node index, left-filled flag
    int unsigned            open_depth;
    int unsigned            node_count;
    logic                   want_sym;
    logic                   ready;
    logic                   failed;
    logic [NODE_AW-1:0]     walk;

    sym_word_t expected_q[$];

    function automatic void clear_tree();
        open_depth = 0;
        node_count = 0;
        want_sym   = 1'b0;
        ready      = 1'b0;
        failed     = 1'b0;
        walk       = '0;
    endfunction

    function automatic bit load_tree_byte(input logic [7:0] tb, output sym_word_t res);
        int unsigned      n;
        int unsigned      room;
        logic [NODE_AW:0] top;
        logic [NODE_AW-1:0] parent;
        res = '0;
        if (ready || failed)
            return 1'b0;
        if (want_sym) begin
            leaf_sym[node_count-1] = tb;
            want_sym = 1'b0;
            if (open_depth == 0) begin
                ready    = 1'b1;
                walk     = '0;
                res.done = 1'b1;
                return 1'b1;
            end
            return 1'b0;
        end
        n = node_count;
        // table full, or a node with no parent left
        if (n >= MAX_NODES || (n > 0 && open_depth == 0)) begin
            failed  = 1'b1;
            res.err = ERR_OVERFLOW;
            return 1'b1;
        end
        // an inner node needs stack room, after the pop this byte may cause
        if (tb != LEAF_MARK) begin
            room = open_depth;
            if (n > 0 && open_stack[open_depth-1][0])
                room--;
            if (room >= STACK_DEPTH) begin
                failed  = 1'b1;
                res.err = ERR_OVERFLOW;
                return 1'b1;
            end
        end
        if (n > 0) begin
            top    = open_stack[open_depth-1];
            parent = top[NODE_AW:1];
            if (!top[0]) begin
                left_of[parent] = NODE_AW'(n);
                open_stack[open_depth-1][0] = 1'b1;
            end else begin
                right_of[parent] = NODE_AW'(n);
                open_depth--;
            end
        end
        node_count  = n + 1;
        left_of[n]  = '0;
        right_of[n] = '0;
        leaf_sym[n] = '0;
        if (tb == LEAF_MARK) begin
            leaf_flag[n] = 1'b1;
            want_sym     = 1'b1;
        end else begin
            leaf_flag[n] = 1'b0;
            open_stack[open_depth] = {NODE_AW'(n), 1'b0};
            open_depth++;
        end
        return 1'b0;
    endfunction

    function automatic bit decode_code_bit(input logic cb, input logic lb,
                                           output sym_word_t res);
        logic [NODE_AW-1:0] child;
        res = '0;
        if (!ready) begin
            res.err = ERR_NOT_READY;
            return 1'b1;
        end
        // single-leaf tree: the root itself is the leaf
        if (leaf_flag[walk]) begin
            res.symbol    = leaf_sym[walk];
            res.sym_valid = 1'b1;
            walk          = '0;
            return 1'b1;
        end
        child = cb ? right_of[walk] : left_of[walk];
        if (leaf_flag[child]) begin
            res.symbol    = leaf_sym[child];
            res.sym_valid = 1'b1;
            walk          = '0;
            return 1'b1;
        end
        if (lb) begin
            walk    = '0;
            res.err = ERR_MID_CODE;
            return 1'b1;
        end
        walk = child;
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        // keep the log short on a badly broken block
        if (fail_count <= 100)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h, want %h", name, got, want));
    endtask

    always @(posedge aclk) begin
        sym_word_t got;
        sym_word_t want;
        sym_word_t res;
        bit        has;
        if (!aresetn) begin
            clear_tree();
            expected_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[7:0], m_tdata[8], m_tdata[9], err_t'(m_tdata[11:10])};
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result word %h with none expected", m_tdata));
                end else begin
                    want = expected_q.pop_front();
                    check_field("symbol", got.symbol, want.symbol);
                    check_field("symbol_valid", got.sym_valid, want.sym_valid);
                    check_field("tree_complete", got.done, want.done);
                    check_field("error_code", got.err, want.err);
                end
            end
            if (s_tvalid && s_tready) begin
                n_words++;
                if (s_tuser == OP_BIT) begin
                    has = decode_code_bit(s_tdata[9], s_tlast, res);
                end else begin
                    if (s_tdata[0])
                        clear_tree();
                    has = load_tree_byte(s_tdata[8:1], res);
                end
                if (has) begin
                    expected_q.push_back(res);
                    if (res.sym_valid)
                        n_symbols++;
                    if (res.done)
                        n_trees++;
                    if (res.err != ERR_NONE)
                        n_errors++;
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

// File: sim/tb_huffman_tree_load_and_decode.sv
// ----------------------------------------------------------------------------
// tb_huffman_tree_load_and_decode
// drives preorder trees and code bit streams into the decoder under random
// back-pressure; a checker beside the block predicts and compares results
// ----------------------------------------------------------------------------
module tb_huffman_tree_load_and_decode;
    timeunit 1ns;
    timeprecision 1ps;
    import hdtl_pkg::*;

    // clock, reset and the two stream channels
    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // tree_start, tree_byte[7:0], code_bit, zero fill
    logic        s_tuser  = 1'b0; // operation
    logic        s_tlast  = 1'b0; // last_bit
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // symbol[7:0], symbol_valid, tree_complete,
                                  // error_code[1:0], zero fill

    // results of the checker
    int fail_count;
    int pending;
    int n_words;
    int n_symbols;
    int n_trees;
    int n_errors;

    // traffic shaping shared by sender and receiver
    bit no_idle   = 1'b0;   // stretch where neither side idles
    int hold_asks = 0;      // bumped to ask the receiver for a long hold-off

    logic [7:0] tree_bytes[$];   // preorder bytes of the tree being sent

    huffman_tree_load_and_decode u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    hdtl_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending),
        .n_words    (n_words),
        .n_symbols  (n_symbols),
        .n_trees    (n_trees),
        .n_errors   (n_errors)
    );

    // 100 MHz clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop if the run hangs
    initial begin
        #5_000_000;
        $display("** huffman_tree_load_and_decode: FAILED **");
        $finish;
    end

    // receiver: random stalls with a chance of 8 in 100, plus a long hold-off on request
    initial begin
        int hold_done;
        hold_done = 0;
        forever begin
            @(posedge aclk);
            if (hold_asks != hold_done) begin
                hold_done = hold_asks;
                m_tready <= 1'b0;
                // long enough for the block to back up and drop s_tready
                repeat (80) @(posedge aclk);
            end else if (no_idle || $urandom_range(99) >= 8) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
            end
        end
    end

    // offer one word, with a random gap first, and wait for its handshake
    task automatic send_word(input logic op, input logic start, input logic [7:0] tb,
                             input logic cb, input logic lb);
        while (!no_idle && $urandom_range(99) < 8) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= lb;
        s_tdata  <= {6'd0, cb, tb, start};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // tree byte; the code bit fields are don't-care and get random values
    task automatic send_tree_byte(input logic start, input logic [7:0] tb);
        send_word(OP_TREE, start, tb, 1'($urandom), 1'($urandom));
    endtask

    // code bit; tree_start and tree_byte are don't-care and get random values
    task automatic send_code_bit(input logic cb, input logic lb);
        send_word(OP_BIT, 1'($urandom), 8'($urandom), cb, lb);
    endtask

    // sender pause: drop valid and wait until every expected word has come
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // any byte other than the leaf marker is an inner node
    function automatic logic [7:0] random_inner_byte();
        logic [7:0] b;
        b = 8'($urandom);
        while (b == LEAF_MARK)
            b = 8'($urandom);
        return b;
    endfunction

    // random full binary tree with the given leaf count, in preorder
    task automatic build_tree(input int leaves);
        int slots;
        int leaves_left;
        tree_bytes.delete();
        slots       = 1;
        leaves_left = leaves;
        while (slots > 0) begin
            // an inner node is only allowed while enough leaves remain for its slots
            if (leaves_left > slots && $urandom_range(1) == 1) begin
                tree_bytes.push_back(random_inner_byte());
                slots++;
            end else begin
                tree_bytes.push_back(LEAF_MARK);
                tree_bytes.push_back(8'($urandom));
                slots--;
                leaves_left--;
            end
        end
    endtask

    // first count bytes of tree_bytes, tree_start only on the first
    task automatic send_tree(input logic start, input int count);
        for (int i = 0; i < count; i++)
            send_tree_byte(i == 0 ? start : 1'b0, tree_bytes[i]);
    endtask

    // right-leaning chain: each inner node has a leaf on its left
    task automatic send_right_chain(input int pairs);
        for (int i = 0; i < pairs; i++) begin
            send_tree_byte(i == 0, random_inner_byte());
            send_tree_byte(1'b0, LEAF_MARK);
            send_tree_byte(1'b0, 8'($urandom));
        end
    endtask

    // main stimulus
    initial begin
        int seq;
        int kind;
        int nbits;
        int cut;
        int good_words;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---------------- directed part ----------------
        // code bit before any tree: not ready
        send_code_bit(1'b0, 1'b0);
        // leaf with no tree_start right after reset, symbol zero
        send_tree_byte(1'b0, LEAF_MARK);
        send_tree_byte(1'b0, 8'h00);
        // single-leaf tree: every bit gives the root symbol
        send_code_bit(1'b0, 1'b0);
        send_code_bit(1'b1, 1'b1);
        // byte after completion without a start is dropped
        send_tree_byte(1'b0, 8'hAA);
        // root(ff) -> leaf ff | inner(00) -> leaf 4c | leaf 00
        send_tree_byte(1'b1, 8'hFF);
        send_tree_byte(1'b0, LEAF_MARK);
        send_tree_byte(1'b0, 8'hFF);
        send_tree_byte(1'b0, 8'h00);
        send_tree_byte(1'b0, LEAF_MARK);
        send_tree_byte(1'b0, LEAF_MARK);
        send_tree_byte(1'b0, LEAF_MARK);
        send_tree_byte(1'b0, 8'h00);
        send_code_bit(1'b0, 1'b0);
        send_code_bit(1'b1, 1'b0);
        send_code_bit(1'b0, 1'b0);
        send_code_bit(1'b1, 1'b0);
        send_code_bit(1'b1, 1'b1);
        // stream ends on an inner node
        send_code_bit(1'b1, 1'b1);
        // last bit landing on a leaf
        send_code_bit(1'b0, 1'b1);
        // half-loaded tree, then a bit: not ready
        send_tree_byte(1'b1, 8'h12);
        send_code_bit(1'b1, 1'b0);
        // restart while a leaf symbol is still awaited
        send_tree_byte(1'b1, LEAF_MARK);
        send_tree_byte(1'b1, LEAF_MARK);
        send_tree_byte(1'b0, 8'h7E);
        send_code_bit(1'b1, 1'b0);
        wait_drained();

        // ---------------- random part ----------------
        seq        = 0;
        good_words = 0;
        while (good_words < 600) begin
            seq++;
            no_idle = (seq >= 15 && seq < 30);
            // long receiver hold-off while words keep coming
            if (seq == 40)
                hold_asks++;
            if (seq == 60)
                wait_drained();
            kind = $urandom_range(99);
            if (kind < 80) begin
                // well-formed tree, mostly small, then a bit stream
                build_tree($urandom_range(9) == 0 ? $urandom_range(13, 40)
                                                   : $urandom_range(1, 12));
                // now and then no tree_start, so it is ignored or extends a partial load
                send_tree($urandom_range(9) != 0, tree_bytes.size());
                nbits = $urandom_range(1, 30);
                for (int i = 0; i < nbits; i++)
                    send_code_bit(1'($urandom),
                                  (i == nbits - 1) ? 1'b1 : ($urandom_range(15) == 0));
                good_words += tree_bytes.size() + nbits;
            end else if (kind < 90) begin
                // truncated tree, then bits that find it not ready
                build_tree($urandom_range(2, 8));
                cut = $urandom_range(1, tree_bytes.size() - 1);
                send_tree(1'b1, cut);
                repeat ($urandom_range(1, 3))
                    send_code_bit(1'($urandom), 1'($urandom));
            end else begin
                // raw noise, every field random
                repeat ($urandom_range(1, 8))
                    send_word(1'($urandom), 1'($urandom), 8'($urandom),
                              1'($urandom), 1'($urandom));
            end
        end
        no_idle = 1'b0;
        wait_drained();

        // ---------------- largest trees ----------------
        // full table: 255 inner nodes and 256 leaves
        send_right_chain(255);
        send_tree_byte(1'b0, LEAF_MARK);
        send_tree_byte(1'b0, 8'($urandom));
        // mostly ones to walk deep down the chain
        for (int i = 0; i < 400; i++)
            send_code_bit($urandom_range(31) != 0, i == 399);
        // table overflow: the byte after node 511
        send_right_chain(255);
        send_tree_byte(1'b0, random_inner_byte());
        send_tree_byte(1'b0, LEAF_MARK);
        send_tree_byte(1'b0, 8'h33);          // ignored after the failed load
        send_code_bit(1'b1, 1'b0);
        // stack: fill 256 deep, a pop-then-push fits, the next push overflows
        for (int i = 0; i < 256; i++)
            send_tree_byte(i == 0, random_inner_byte());
        send_tree_byte(1'b0, LEAF_MARK);
        send_tree_byte(1'b0, 8'($urandom));
        send_tree_byte(1'b0, random_inner_byte());
        send_tree_byte(1'b0, random_inner_byte());
        send_code_bit(1'b0, 1'b1);

        // ---------------- drain and verdict ----------------
        wait_drained();
        repeat (20) @(posedge aclk);
        $display("run covered %0d words: %0d trees completed, %0d symbols decoded,",
                 n_words, n_trees, n_symbols);
        $display("%0d error words, table and stack overflow, single-leaf and mid-code ends",
                 n_errors);
        if (fail_count == 0 && pending == 0) begin
            $display("** huffman_tree_load_and_decode: PASSED **");
        end else begin
            $display("** huffman_tree_load_and_decode: FAILED **");
        end
        $finish;
    end

endmodule
